/* src/pspf_pkg.sv */
// Shared types and constants for the particulate sensor frame parser.
// Used by the front, queue, back and top level; depends on nothing.
`timescale 1ns / 1ps

package pspf_pkg;

  // Framing bytes of the sensor serial protocol.
  localparam logic [7:0] START_BYTE  = 8'h42;
  localparam logic [7:0] SECOND_BYTE = 8'h4d;

  // Reset value of the sequence top register.
  localparam logic [7:0] SEQ_TOP_RESET = 8'd29;

  // Byte positions inside a frame, counted from the start byte.
  localparam int HDR2_IDX    = 1;
  localparam int PM25_HI_IDX = 6;
  localparam int PM25_LO_IDX = 7;
  localparam int PM10_HI_IDX = 8;
  localparam int PM10_LO_IDX = 9;

  // Depth of the frame record queue between front and back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // One parsed frame handed from the front to the back.
  typedef struct packed {
    logic        ok;
    logic [15:0] pm25;
    logic [15:0] pm10;
  } frame_rec_t;

endpackage

/* src/particulate_sensor_frame_parser_unit.sv */
// Particulate sensor frame parser: one serial byte per cycle in while full is low,
// one result per frame out. Each frame's record enters the record queue on its last
// byte and moves into the result register once that register is free.
// Throughput: one byte every cycle while full is low; full rises only with two records
// queued and one result waiting, so three frames are buffered against a stalled consumer.
// Reset: hunting for the start byte, count zero, queues empty, sequence top 29.
`timescale 1ns / 1ps

module particulate_sensor_frame_parser_unit
  import pspf_pkg::*;
#(
  parameter int FRAME_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_sequence_top_i,
  output logic        empty,
  input  logic        pop,
  output logic        frame_ok_o,
  output logic [15:0] pm25_value_o,
  output logic [15:0] pm10_value_o,
  output logic [7:0]  sequence_number_o
);

  logic       byte_valid;
  logic       rec_wr;
  frame_rec_t rec_wr_data;
  logic       rec_rd;
  frame_rec_t rec_rd_data;
  logic       rec_empty;
  logic       rec_full;

  // The register is always writable.
  assign cfg_ready_o = 1'b1;
  assign full        = rec_full;
  assign byte_valid  = push && !rec_full;

  pspf_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_valid),
    .rx_byte_i   (rx_byte_i),
    .rec_valid_o (rec_wr),
    .rec_o       (rec_wr_data)
  );

  pspf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (rec_wr),
    .wr_rec_i(rec_wr_data),
    .rd_i    (rec_rd),
    .rd_rec_o(rec_rd_data),
    .empty_o (rec_empty),
    .full_o  (rec_full)
  );

  pspf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_sequence_top_i),
    .rec_empty_i      (rec_empty),
    .rec_i            (rec_rd_data),
    .rec_rd_o         (rec_rd),
    .pop_i            (pop),
    .empty_o          (empty),
    .frame_ok_o       (frame_ok_o),
    .pm25_value_o     (pm25_value_o),
    .pm10_value_o     (pm10_value_o),
    .sequence_number_o(sequence_number_o)
  );

endmodule

/* src/pspf_front.sv */
// Front part: tracks the frame position, keeps the running sum and captured words.
// Depends on pspf_pkg; emits one frame record on the last byte of each frame.
`timescale 1ns / 1ps

module pspf_front
  import pspf_pkg::*;
#(
  parameter int FRAME_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       rec_valid_o,
  output frame_rec_t rec_o
);

  localparam int IDX_W = $clog2(FRAME_BYTES);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       hdr_q, hdr_d;
  logic [15:0]      pm25_q, pm25_d;
  logic [15:0]      pm10_q, pm10_d;
  logic [7:0]       chk_hi_q, chk_hi_d;

  // Byte classification and field capture.
  always_comb begin
    idx_d       = idx_q;
    sum_d       = sum_q;
    hdr_d       = hdr_q;
    pm25_d      = pm25_q;
    pm10_d      = pm10_q;
    chk_hi_d    = chk_hi_q;
    rec_valid_o = 1'b0;
    rec_o.ok    = (hdr_q == SECOND_BYTE) && ({chk_hi_q, rx_byte_i} == sum_q);
    rec_o.pm25  = pm25_q;
    rec_o.pm10  = pm10_q;
    if (byte_valid_i) begin
      if (idx_q == '0) begin
        // Hunting: only the start byte opens a frame.
        if (rx_byte_i == START_BYTE) begin
          sum_d = {8'h00, rx_byte_i};
          idx_d = IDX_W'(1);
        end
      end else begin
        if (idx_q == IDX_W'(HDR2_IDX))    hdr_d          = rx_byte_i;
        if (idx_q == IDX_W'(PM25_HI_IDX)) pm25_d[15:8]   = rx_byte_i;
        if (idx_q == IDX_W'(PM25_LO_IDX)) pm25_d[7:0]    = rx_byte_i;
        if (idx_q == IDX_W'(PM10_HI_IDX)) pm10_d[15:8]   = rx_byte_i;
        if (idx_q == IDX_W'(PM10_LO_IDX)) pm10_d[7:0]    = rx_byte_i;
        if (idx_q < IDX_W'(FRAME_BYTES - 2)) begin
          sum_d = sum_q + {8'h00, rx_byte_i};
          idx_d = idx_q + IDX_W'(1);
        end else if (idx_q == IDX_W'(FRAME_BYTES - 2)) begin
          chk_hi_d = rx_byte_i;
          idx_d    = idx_q + IDX_W'(1);
        end else begin
          // Last byte: close the frame and go back to hunting.
          idx_d       = '0;
          rec_valid_o = 1'b1;
        end
      end
    end
  end

  // Frame position is control state; captured words need no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    hdr_q    <= hdr_d;
    pm25_q   <= pm25_d;
    pm10_q   <= pm10_d;
    chk_hi_q <= chk_hi_d;
  end

  // A record leaves only on the last byte of a frame.
  a_rec_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o |-> (idx_q == IDX_W'(FRAME_BYTES - 1)) && byte_valid_i)
    else $error("frame record without last byte");

endmodule

/* src/pspf_queue.sv */
// Short register queue of frame records between the front and the back.
// Depends on pspf_pkg for the record type and the depth.
`timescale 1ns / 1ps

module pspf_queue
  import pspf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  frame_rec_t wr_rec_i,
  input  logic       rd_i,
  output frame_rec_t rd_rec_o,
  output logic       empty_o,
  output logic       full_o
);

  frame_rec_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign empty_o  = (cnt_q == '0);
  assign full_o   = (cnt_q == QCNT_W'(QDEPTH));
  assign rd_rec_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  // Record storage.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_rec_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && full_o && !rd_i))
    else $error("record queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_i && empty_o))
    else $error("record queue underflow");

endmodule

/* src/pspf_back.sv */
// Back part: counts good frames and holds the result word for the consumer.
// Depends on pspf_pkg; owns the sequence top register.
`timescale 1ns / 1ps

module pspf_back
  import pspf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        rec_empty_i,
  input  frame_rec_t  rec_i,
  output logic        rec_rd_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic        frame_ok_o,
  output logic [15:0] pm25_value_o,
  output logic [15:0] pm10_value_o,
  output logic [7:0]  sequence_number_o
);

  logic [7:0]  seq_top_q;
  logic [7:0]  cnt_q, cnt_d;
  logic [8:0]  cnt_inc;
  logic        out_valid_q;
  logic        ok_q;
  logic [15:0] pm25_q, pm10_q;
  logic [7:0]  seq_q;
  logic        load;

  // Take a record when the output word is free or being taken.
  assign load     = !rec_empty_i && (!out_valid_q || pop_i);
  assign rec_rd_o = load;

  // Good frames advance the count and wrap past the top.
  always_comb begin
    cnt_inc = {1'b0, cnt_q} + 9'd1;
    cnt_d   = cnt_q;
    if (rec_i.ok) begin
      cnt_d = (cnt_inc > {1'b0, seq_top_q}) ? 8'd0 : cnt_inc[7:0];
    end
  end

  // Control state: sequence top, good count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_top_q   <= SEQ_TOP_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        seq_top_q <= cfg_data_i;
      end
      if (load) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word.
  always_ff @(posedge clk_i) begin
    if (load) begin
      ok_q   <= rec_i.ok;
      pm25_q <= rec_i.pm25;
      pm10_q <= rec_i.pm10;
      seq_q  <= cnt_d;
    end
  end

  assign empty_o           = !out_valid_q;
  assign frame_ok_o        = ok_q;
  assign pm25_value_o      = pm25_q;
  assign pm10_value_o      = pm10_q;
  assign sequence_number_o = seq_q;

  a_bad_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !rec_i.ok) |=> (cnt_q == $past(cnt_q)) && (seq_q == cnt_q))
    else $error("bad frame changed the sequence count");

  a_good_steps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && rec_i.ok) |=> (cnt_q == 8'd0) || (cnt_q == $past(cnt_q) + 8'd1))
    else $error("good frame count step wrong");

endmodule
